@@ design/swt_pkg.sv @@
// Shared types, character codes and helpers for the shell word tokenizer.
package swt_pkg;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BTICK  = 8'h60;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [1:0] QM_NONE   = 2'd0;
	localparam logic [1:0] QM_SINGLE = 2'd1;
	localparam logic [1:0] QM_DOUBLE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_LONG  = 2'd1;
	localparam logic [1:0] ST_QUOTE = 2'd2;

	localparam logic [16:0] COUNT_MAX       = 17'h1FFFF;
	localparam logic [15:0] MAX_LEN_DEFAULT = 16'd1024;

	typedef struct packed {
		logic [7:0] char_out;
		logic       char_valid;
		logic       word_end;
		logic       line_end;
		logic [1:0] line_status;
	} result_t;

	typedef struct packed {
		logic        word_open;
		logic [1:0]  quote_mode;
		logic        escape_pending;
		logic [16:0] byte_count;
	} tok_state_t;

	typedef struct packed {
		logic [1:0]        cnt;
		result_t [2:0]     res;
	} group_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_dq_escapable(input logic [7:0] c);
		return (c == CH_DQUOTE) || (c == CH_BSLASH) || (c == CH_DOLLAR) || (c == CH_BTICK);
	endfunction

	function automatic result_t char_result(input logic [7:0] c);
		result_t r;
		r = '0;
		r.char_out   = c;
		r.char_valid = 1'b1;
		return r;
	endfunction

endpackage

@@ design/swt_decode.sv @@
// Per-byte decoder: next tokenizer state and the group of results one byte causes.
module swt_decode
	import swt_pkg::*;
(
	input  logic [7:0]  byte_s1,
	input  logic        last_s1,
	input  tok_state_t  st,
	input  logic [15:0] max_len,
	output tok_state_t  nxt,
	output group_t      grp
);

	logic [16:0] cnt_inc;
	logic [1:0]  n;
	logic        done;
	logic        outside;
	logic [7:0]  qc;
	logic [1:0]  status;
	result_t     le_res;

	always_comb begin
		nxt     = st;
		n       = 2'd0;
		grp     = '0;
		done    = 1'b0;
		outside = 1'b0;
		qc      = CH_SQUOTE;
		status  = ST_OK;
		le_res  = '0;

		cnt_inc = (st.byte_count != COUNT_MAX) ? st.byte_count + 17'd1 : st.byte_count;
		nxt.byte_count = cnt_inc;

		if (st.quote_mode == QM_DOUBLE && st.escape_pending) begin
			nxt.escape_pending = 1'b0;
			done = 1'b1;
			if (is_dq_escapable(byte_s1)) begin
				grp.res[0] = char_result(byte_s1);
				n = 2'd1;
			end else begin
				grp.res[0] = char_result(CH_BSLASH);
				grp.res[1] = char_result(byte_s1);
				n = 2'd2;
			end
		end else if (st.escape_pending) begin
			nxt.escape_pending = 1'b0;
			nxt.quote_mode     = QM_NONE;
			nxt.word_open      = 1'b1;
			grp.res[0] = char_result(byte_s1);
			n = 2'd1;
			done = 1'b1;
		end

		if (!done) begin
			if (st.quote_mode == QM_SINGLE || st.quote_mode == QM_DOUBLE) begin
				qc = (st.quote_mode == QM_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
				if (st.quote_mode == QM_DOUBLE && byte_s1 == CH_BSLASH && !last_s1) begin
					nxt.escape_pending = 1'b1;
				end else if (byte_s1 == qc) begin
					nxt.quote_mode = QM_NONE;
				end else begin
					grp.res[0] = char_result(byte_s1);
					n = 2'd1;
				end
			end else begin
				nxt.quote_mode = QM_NONE;
				outside = 1'b1;
			end
		end

		if (outside) begin
			if (byte_s1 == CH_DQUOTE || byte_s1 == CH_SQUOTE) begin
				nxt.quote_mode = (byte_s1 == CH_SQUOTE) ? QM_SINGLE : QM_DOUBLE;
				nxt.word_open  = 1'b1;
			end else if (is_space(byte_s1)) begin
				if (st.word_open) begin
					grp.res[0] = '0;
					grp.res[0].word_end = 1'b1;
					n = 2'd1;
				end
				nxt.word_open = 1'b0;
			end else if (byte_s1 == CH_BSLASH && !last_s1) begin
				nxt.escape_pending = 1'b1;
			end else begin
				grp.res[0] = char_result(byte_s1);
				n = 2'd1;
				nxt.word_open = 1'b1;
			end
		end

		if (last_s1) begin
			if (cnt_inc > {1'b0, max_len}) begin
				status = ST_LONG;
			end else if (nxt.quote_mode != QM_NONE) begin
				status = ST_QUOTE;
			end
			le_res.word_end    = nxt.word_open && (status == ST_OK);
			le_res.line_end    = 1'b1;
			le_res.line_status = status;
			grp.res[n] = le_res;
			n = n + 2'd1;
			nxt = '0;
		end

		grp.cnt = n;
	end

endmodule

@@ design/swt_result_buf.sv @@
// Result group register: holds the results of one byte and hands them out in order.
module swt_result_buf
	import swt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  group_t  grp,
	output logic    free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t head,
	output logic    head_last
);

	result_t [2:0] res_q;
	logic [1:0]    cnt_q;
	logic [1:0]    idx_q;
	logic          valid_q;

	assign head_last = (idx_q == cnt_q - 2'd1);
	assign head      = res_q[idx_q];
	assign out_valid = valid_q;
	assign free      = !valid_q || (out_ready && head_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= 2'd0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= grp.cnt;
			idx_q   <= 2'd0;
		end else if (valid_q && out_ready) begin
			if (head_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= grp.res;
		end
	end

endmodule

@@ design/shell_word_tokenizer.sv @@
// Top level of the shell word tokenizer: input stage, state, decoder and result register.
// Path: a byte passes the input stage register and then the result group register before its
// first result is offered; while the result register is busy the byte waits in the input stage.
// Throughput: one byte per cycle while the result group register can take its group; a byte
// causing k results (k up to 3) keeps that register busy until all k are taken, the limit.
// Reset: arst_n clears the input stage, tokenizer state and result register at once
// and sets max_len_q to 1024; no clearing pass.
module shell_word_tokenizer
	import swt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	input  logic        line_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  char_out,
	output logic        char_valid,
	output logic        word_end,
	output logic        line_end,
	output logic [1:0]  line_status,
	output logic        run_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	tok_state_t  state_q;
	tok_state_t  state_nxt;
	logic [15:0] max_len_q;
	group_t      grp;
	logic        buf_free;
	logic        consume;
	logic        load;
	result_t     head;

	assign cfg_ready = 1'b1;
	assign consume   = valid_s1 && ((grp.cnt == 2'd0) || buf_free);
	assign load      = valid_s1 && (grp.cnt != 2'd0) && buf_free;
	assign in_ready  = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_DEFAULT;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	// hold the request until the decoder consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (consume) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
			last_s1 <= line_last;
		end
	end

	swt_decode u_decode (
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.st      (state_q),
		.max_len (max_len_q),
		.nxt     (state_nxt),
		.grp     (grp)
	);

	swt_result_buf u_result_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.grp       (grp),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head),
		.head_last (run_last)
	);

	assign char_out    = head.char_out;
	assign char_valid  = head.char_valid;
	assign word_end    = head.word_end;
	assign line_end    = head.line_end;
	assign line_status = head.line_status;

endmodule

@@ design/swt_checker.sv @@
// Port-level checker for the shell word tokenizer, bound to the top level.
module swt_checker
	import swt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] char_out,
	input logic       char_valid,
	input logic       word_end,
	input logic       line_end,
	input logic [1:0] line_status,
	input logic       run_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(char_valid)
			&& $stable(word_end) && $stable(line_end) && $stable(line_status)
			&& $stable(run_last))
		else $error("result changed while stalled");

	a_line_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_end |-> run_last)
		else $error("line end not the last result of its byte");

	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_end |-> line_status == ST_OK)
		else $error("status outside line end");

	a_char_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> !word_end && !line_end)
		else $error("word byte mixed with a mark");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> char_out == 8'd0)
		else $error("mark result carries a byte");

endmodule

bind shell_word_tokenizer swt_checker u_swt_checker (.*);
